@@ hdl/scc_pkg.sv @@
// Shared widths, operation and status codes, and controller/datapath link types.
package scc_pkg;

   localparam int SLOTS_DEF        = 64;
   localparam int SECTOR_BYTES_DEF = 512;

   localparam int OP_W         = 2;
   localparam int SECTOR_W     = 32;
   localparam int OFFSET_W     = 10;
   localparam int SIZE_W       = 16;
   localparam int STATUS_W     = 3;
   localparam int SLOT_FIELD_W = 6;
   localparam int BYTES_W      = 10;
   localparam int TOTAL_W      = 32;
   localparam int CALC_W       = SIZE_W + 1;

   localparam logic [OP_W-1:0] OP_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_HIT        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISS       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_REJECT     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FLUSH_WB   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FLUSH_NONE = 3'd4;

   typedef struct packed {
      logic                take_req;
      logic                lookup;
      logic                flush_pick;
      logic                sweep;
      logic                rd_hand;
      logic                emit;
      logic [STATUS_W-1:0] emit_kind;
   } cmd_type;

   typedef struct packed {
      logic            accepted;
      logic [OP_W-1:0] op;
      logic            reject;
      logic            hit;
      logic            any_dirty;
      logic            victim;
      logic            out_free;
      logic            flush_last;
   } stat_type;

endpackage

@@ hdl/scc_req_if.sv @@
// Request channel: access or flush beat with valid/ready handshake.
interface scc_req_if;
   logic                          valid;
   logic                          ready;
   logic [scc_pkg::OP_W-1:0]      op;
   logic [scc_pkg::SECTOR_W-1:0]  sector;
   logic [scc_pkg::OFFSET_W-1:0]  offset;
   logic [scc_pkg::SIZE_W-1:0]    size;

   modport source (output valid, op, sector, offset, size, input ready);
   modport sink   (input valid, op, sector, offset, size, output ready);
endinterface

@@ hdl/scc_rsp_if.sv @@
// Response channel: one result beat per hit, miss, reject or flushed slot, or one for a flush with no dirty slot.
interface scc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [scc_pkg::STATUS_W-1:0]      status;
   logic [scc_pkg::SLOT_FIELD_W-1:0]  slot;
   logic                              fetch_needed;
   logic                              writeback_needed;
   logic [scc_pkg::SECTOR_W-1:0]      writeback_sector;
   logic [scc_pkg::BYTES_W-1:0]       byte_count;
   logic                              last;
   logic [scc_pkg::TOTAL_W-1:0]       access_total;
   logic [scc_pkg::TOTAL_W-1:0]       hit_total;
   logic [scc_pkg::TOTAL_W-1:0]       fetch_total;
   logic [scc_pkg::TOTAL_W-1:0]       writeback_total;

   modport source (output valid, status, slot, fetch_needed, writeback_needed,
                   writeback_sector, byte_count, last, access_total, hit_total,
                   fetch_total, writeback_total, input ready);
   modport sink   (input valid, status, slot, fetch_needed, writeback_needed,
                   writeback_sector, byte_count, last, access_total, hit_total,
                   fetch_total, writeback_total, output ready);
endinterface

@@ hdl/scc_ctrl.sv @@
// Sequencer for lookup, clock sweep, flush scan and result beats.
module scc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  scc_pkg::stat_type stat,
   output scc_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_LOOKUP   = 4'd2;
   localparam logic [3:0] S_HIT      = 4'd3;
   localparam logic [3:0] S_SWEEP    = 4'd4;
   localparam logic [3:0] S_MISS     = 4'd5;
   localparam logic [3:0] S_REJECT   = 4'd6;
   localparam logic [3:0] S_FL_PICK  = 4'd7;
   localparam logic [3:0] S_FL_READ  = 4'd8;
   localparam logic [3:0] S_FL_EMIT  = 4'd9;
   localparam logic [3:0] S_FL_NONE  = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.take_req = 1'b1;
            if (stat.accepted) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (stat.op == scc_pkg::OP_NONE) state_in = S_IDLE;
            else if (stat.op == scc_pkg::OP_FLUSH) state_in = S_FL_PICK;
            else if (stat.reject) state_in = S_REJECT;
            else state_in = S_LOOKUP;
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = stat.hit ? S_HIT : S_SWEEP;
         end
         S_HIT: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = scc_pkg::ST_HIT;
               state_in      = S_IDLE;
            end
         end
         S_SWEEP: begin
            cmd.sweep   = 1'b1;
            cmd.rd_hand = 1'b1;
            if (stat.victim) state_in = S_MISS;
         end
         S_MISS: begin
            cmd.rd_hand = 1'b1;
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = scc_pkg::ST_MISS;
               state_in      = S_IDLE;
            end
         end
         S_REJECT: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = scc_pkg::ST_REJECT;
               state_in      = S_IDLE;
            end
         end
         S_FL_PICK: begin
            cmd.flush_pick = 1'b1;
            state_in       = stat.any_dirty ? S_FL_READ : S_FL_NONE;
         end
         S_FL_READ: begin
            state_in = S_FL_EMIT;
         end
         S_FL_EMIT: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = scc_pkg::ST_FLUSH_WB;
               state_in      = stat.flush_last ? S_IDLE : S_FL_PICK;
            end
         end
         S_FL_NONE: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = scc_pkg::ST_FLUSH_NONE;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/scc_dpath.sv @@
// Slot tags and flags, clock hand, counters, tag memory and result register.
module scc_dpath #(
   parameter int SLOTS        = scc_pkg::SLOTS_DEF,
   parameter int SECTOR_BYTES = scc_pkg::SECTOR_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   scc_req_if.sink           req_bus,
   scc_rsp_if.source         rsp_bus,
   input  scc_pkg::cmd_type  cmd,
   output scc_pkg::stat_type stat
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [scc_pkg::CALC_W-1:0] SB_C = scc_pkg::CALC_W'(SECTOR_BYTES);

   logic [scc_pkg::OP_W-1:0]     op_ff;
   logic [scc_pkg::SECTOR_W-1:0] sector_ff;
   logic [scc_pkg::OFFSET_W-1:0] offset_ff;
   logic [scc_pkg::SIZE_W-1:0]   size_ff;

   logic [scc_pkg::SECTOR_W-1:0] tag_ff  [SLOTS];
   logic [scc_pkg::SECTOR_W-1:0] tag_mem [SLOTS];
   logic [scc_pkg::SECTOR_W-1:0] tag_rd_ff;
   logic [IDX_W-1:0]             rd_addr;

   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [SLOTS-1:0] used_ff, used_in;
   logic [SLOTS-1:0] dirty_ff, dirty_in;
   logic [SLOTS-1:0] match_ff, match_in;
   logic [SLOTS-1:0] enc_vec;
   logic [IDX_W-1:0] enc_idx;
   logic [IDX_W-1:0] hand_ff, hand_in;
   logic [IDX_W-1:0] slot_ff;

   logic [scc_pkg::TOTAL_W-1:0] access_ff, access_in;
   logic [scc_pkg::TOTAL_W-1:0] hit_ff, hit_in;
   logic [scc_pkg::TOTAL_W-1:0] fetch_ff, fetch_in;
   logic [scc_pkg::TOTAL_W-1:0] wb_ff, wb_in;

   logic accept;
   logic out_free;
   logic is_write;
   logic victim;
   logic victim_wb;
   logic flush_last;
   logic reject;
   logic miss_fill;
   logic [scc_pkg::CALC_W-1:0]  left_bytes;
   logic [scc_pkg::CALC_W-1:0]  req_bytes;
   logic [scc_pkg::BYTES_W-1:0] byte_cnt;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [scc_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic [scc_pkg::SLOT_FIELD_W-1:0]  slot_out_ff, slot_out_in;
   logic                              fetch_out_ff, fetch_out_in;
   logic                              wb_out_ff, wb_out_in;
   logic [scc_pkg::SECTOR_W-1:0]      wb_sector_ff, wb_sector_in;
   logic [scc_pkg::BYTES_W-1:0]       bytes_out_ff, bytes_out_in;
   logic                              last_ff, last_in;

   assign req_bus.ready = cmd.take_req;
   assign accept        = req_bus.valid && cmd.take_req;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign is_write      = (op_ff == scc_pkg::OP_WRITE);
   assign victim        = !valid_ff[hand_ff] || !used_ff[hand_ff];
   assign victim_wb     = valid_ff[hand_ff] && dirty_ff[hand_ff];
   assign flush_last    = ((dirty_ff & (dirty_ff - SLOTS'(1))) == '0);
   assign reject        = scc_pkg::CALC_W'(offset_ff) > SB_C;
   assign miss_fill     = cmd.emit && (cmd.emit_kind == scc_pkg::ST_MISS);
   assign left_bytes    = SB_C - scc_pkg::CALC_W'(offset_ff);
   assign req_bytes     = scc_pkg::CALC_W'(size_ff);
   assign byte_cnt      = (req_bytes < left_bytes) ? req_bytes[scc_pkg::BYTES_W-1:0]
                                                   : left_bytes[scc_pkg::BYTES_W-1:0];
   assign rd_addr       = cmd.rd_hand ? hand_ff : slot_ff;
   assign enc_vec       = cmd.flush_pick ? dirty_ff : match_ff;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         match_in[i] = valid_ff[i] && (tag_ff[i] == sector_ff);
      end
   end

   always_comb begin
      enc_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (enc_vec[i]) enc_idx = IDX_W'(i);
      end
   end

   always_comb begin
      valid_in     = valid_ff;
      used_in      = used_ff;
      dirty_in     = dirty_ff;
      hand_in      = hand_ff;
      access_in    = access_ff;
      hit_in       = hit_ff;
      fetch_in     = fetch_ff;
      wb_in        = wb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (cmd.sweep && !victim) begin
         used_in[hand_ff] = 1'b0;
         hand_in          = (hand_ff == LAST_IDX) ? '0 : hand_ff + 1'b1;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         case (cmd.emit_kind)
            scc_pkg::ST_HIT: begin
               used_in[slot_ff] = 1'b1;
               if (is_write) dirty_in[slot_ff] = 1'b1;
               access_in = access_ff + 1'b1;
               hit_in    = hit_ff + 1'b1;
            end
            scc_pkg::ST_MISS: begin
               valid_in[hand_ff] = 1'b1;
               used_in[hand_ff]  = 1'b1;
               dirty_in[hand_ff] = is_write;
               access_in = access_ff + 1'b1;
               fetch_in  = fetch_ff + 1'b1;
               if (victim_wb) wb_in = wb_ff + 1'b1;
            end
            scc_pkg::ST_FLUSH_WB: begin
               dirty_in[slot_ff] = 1'b0;
               wb_in             = wb_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      status_in    = cmd.emit_kind;
      slot_out_in  = '0;
      fetch_out_in = 1'b0;
      wb_out_in    = 1'b0;
      bytes_out_in = '0;
      last_in      = 1'b1;
      case (cmd.emit_kind) inside
         scc_pkg::ST_HIT: begin
            slot_out_in  = scc_pkg::SLOT_FIELD_W'(slot_ff);
            bytes_out_in = byte_cnt;
         end
         scc_pkg::ST_MISS: begin
            slot_out_in  = scc_pkg::SLOT_FIELD_W'(hand_ff);
            fetch_out_in = 1'b1;
            wb_out_in    = victim_wb;
            bytes_out_in = byte_cnt;
         end
         scc_pkg::ST_FLUSH_WB: begin
            slot_out_in = scc_pkg::SLOT_FIELD_W'(slot_ff);
            wb_out_in   = 1'b1;
            last_in     = flush_last;
         end
         default: begin
         end
      endcase
      wb_sector_in = wb_out_in ? tag_rd_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_bus.op;
         sector_ff <= req_bus.sector;
         offset_ff <= req_bus.offset;
         size_ff   <= req_bus.size;
      end
      match_ff <= match_in;
      if (cmd.lookup || cmd.flush_pick) slot_ff <= enc_idx;
      if (miss_fill) begin
         tag_ff[hand_ff]  <= sector_ff;
         tag_mem[hand_ff] <= sector_ff;
      end
      tag_rd_ff <= tag_mem[rd_addr];
      if (cmd.emit) begin
         status_ff    <= status_in;
         slot_out_ff  <= slot_out_in;
         fetch_out_ff <= fetch_out_in;
         wb_out_ff    <= wb_out_in;
         wb_sector_ff <= wb_sector_in;
         bytes_out_ff <= bytes_out_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         used_ff      <= '0;
         dirty_ff     <= '0;
         hand_ff      <= '0;
         access_ff    <= '0;
         hit_ff       <= '0;
         fetch_ff     <= '0;
         wb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         used_ff      <= used_in;
         dirty_ff     <= dirty_in;
         hand_ff      <= hand_in;
         access_ff    <= access_in;
         hit_ff       <= hit_in;
         fetch_ff     <= fetch_in;
         wb_ff        <= wb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.status           = status_ff;
   assign rsp_bus.slot             = slot_out_ff;
   assign rsp_bus.fetch_needed     = fetch_out_ff;
   assign rsp_bus.writeback_needed = wb_out_ff;
   assign rsp_bus.writeback_sector = wb_sector_ff;
   assign rsp_bus.byte_count       = bytes_out_ff;
   assign rsp_bus.last             = last_ff;
   assign rsp_bus.access_total     = access_ff;
   assign rsp_bus.hit_total        = hit_ff;
   assign rsp_bus.fetch_total      = fetch_ff;
   assign rsp_bus.writeback_total  = wb_ff;

   assign stat.accepted   = accept;
   assign stat.op         = op_ff;
   assign stat.reject     = reject;
   assign stat.hit        = |match_ff;
   assign stat.any_dirty  = |dirty_ff;
   assign stat.victim     = victim;
   assign stat.out_free   = out_free;
   assign stat.flush_last = flush_last;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("result beat loaded over an untaken beat");

   a_dirty_valid: assert property (@(posedge clock) disable iff (reset)
      (dirty_ff & ~valid_ff) == '0)
      else $error("dirty flag set on an invalid slot");

   a_hand_range: assert property (@(posedge clock) disable iff (reset)
      hand_ff <= LAST_IDX)
      else $error("clock hand out of range");

   a_miss_fill: assert property (@(posedge clock) disable iff (reset)
      miss_fill |=> (valid_ff[hand_ff] && used_ff[hand_ff] && $stable(hand_ff)))
      else $error("miss fill did not claim the victim slot");

endmodule

@@ hdl/sector_cache_clock_policy_unit.sv @@
// Sector cache tag and clock-replacement engine, top level.
// Request beat to result beat: decode, then lookup and a hit beat, a reject beat, or a
// miss sweep in which the hand passes 0 to SLOTS slots before the miss beat; the next
// request beat is taken in the cycle after the result is loaded. Flush: pick, tag read and
// beat per dirty slot; pick and none beat if none. An unknown op frees the input without a
// beat; beats wait on response stalls. Synchronous reset clears flags, hand and counters.
module sector_cache_clock_policy_unit #(
   parameter int SLOTS        = scc_pkg::SLOTS_DEF,
   parameter int SECTOR_BYTES = scc_pkg::SECTOR_BYTES_DEF
) (
   input logic       clock,
   input logic       reset,
   scc_req_if.sink   req_bus,
   scc_rsp_if.source rsp_bus
);

   scc_pkg::cmd_type  cmd;
   scc_pkg::stat_type stat;

   scc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   scc_dpath #(
      .SLOTS        (SLOTS),
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_dpath (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .cmd     (cmd),
      .stat    (stat)
   );

endmodule
